@@ rtl/io_completion_tag_table_assert.svh @@
// Assertion macros of the tag table RTL, used by the datapath.
`ifndef IO_COMPLETION_TAG_TABLE_ASSERT_SVH
`define IO_COMPLETION_TAG_TABLE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define IOCTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IOCTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ioctt_pkg.sv @@
// Types, constants and helper functions of the I/O completion tag table.
`default_nettype none

package ioctt_pkg;

    localparam int SLOTS    = 256;
    localparam int GRP_SZ   = 16;
    localparam int BIT_IW   = 4;
    localparam int NGRP     = (SLOTS + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_IW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NGRP_P   = 1 << GRP_IW;
    localparam int SLOT_N   = NGRP_P * GRP_SZ;
    localparam int SLOT_W   = GRP_IW + BIT_IW;
    localparam int TAG_W    = 16;
    localparam logic [15:0] BCNT_MAX = 16'd65535;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_CPL   = 1'b1;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_EOF    = 2'd1,
        ST_ABORT  = 2'd2
    } t_status;

    typedef struct packed {
        logic               kind;
        logic [6:0]         event_flag;
        logic [31:0]        ast_param;
        logic               has_ast;
        logic               has_status;
        logic               is_read;
        logic [TAG_W-1:0]   tag;
        logic signed [31:0] result;
    } t_req;

    typedef struct packed {
        logic [7:0]  granted_tag;
        logic        table_full;
        logic        tag_valid;
        logic        write_status;
        t_status     status_code;
        logic [15:0] byte_count;
        logic [30:0] device_word;
        logic        set_flag;
        logic [6:0]  flag_number;
        logic        call_ast;
        logic [31:0] ast_param_out;
    } t_rsp;

    typedef struct packed {
        logic [6:0]  flag;
        logic [31:0] param;
        logic        ast;
        logic        status;
        logic        rd;
    } t_ctx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_GRP,
        S_ALLOC_BIT,
        S_CPL_READ,
        S_CPL_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic grp_load;
        logic alloc_commit;
        logic cpl_eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic out_blocked;
    } t_sts;

    function automatic logic [BIT_IW-1:0] lowest_bit(input logic [GRP_SZ-1:0] v);
        logic [BIT_IW-1:0] idx;
        idx = '0;
        for (int i = GRP_SZ - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_IW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [GRP_IW-1:0] lowest_grp(input logic [NGRP_P-1:0] v);
        logic [GRP_IW-1:0] idx;
        idx = '0;
        for (int i = NGRP_P - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GRP_IW'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ioctt_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ioctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/ioctt_ctrl.sv @@
// Controller state machine of the I/O completion tag table.
`default_nettype none

module ioctt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ioctt_pkg::t_sts i_sts,
    output ioctt_pkg::t_cmd    o_cmd
);

    import ioctt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DONE;
                    if (i_sts.kind == KIND_CPL) begin
                        n_state = S_CPL_READ;
                    end else begin
                        n_state = S_ALLOC_GRP;
                    end
                end
            end
            S_ALLOC_GRP: begin
                o_cmd.grp_load = 1'b1;
                n_state = S_ALLOC_BIT;
            end
            S_ALLOC_BIT: begin
                o_cmd.alloc_commit = 1'b1;
                n_state = S_DONE;
            end
            S_CPL_READ: begin
                n_state = S_CPL_EVAL;
            end
            S_CPL_EVAL: begin
                o_cmd.cpl_eval = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ioctt_dpath.sv @@
// Datapath of the I/O completion tag table: busy bits, slot search, context RAM, result.
`default_nettype none
`include "io_completion_tag_table_assert.svh"

module ioctt_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ioctt_pkg::t_req   i_in,
    input  wire ioctt_pkg::t_cmd   i_cmd,
    output ioctt_pkg::t_sts        o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ioctt_pkg::t_rsp        o_out
);

    import ioctt_pkg::*;

    t_req                          r_req;
    t_rsp                          r_res;
    t_rsp                          r_out;
    logic                          r_out_valid;
    logic [SLOT_N-1:0]             r_busy;
    logic [GRP_IW-1:0]             r_grp;
    logic                          r_grp_found;

    logic [NGRP_P-1:0][GRP_SZ-1:0] busy_grp;
    logic [NGRP_P-1:0]             grp_free;
    logic [BIT_IW-1:0]             free_bit;
    logic [SLOT_W-1:0]             alloc_idx;
    logic [SLOT_W-1:0]             cpl_idx;
    logic                          cpl_hit;
    logic                          alloc_we;
    t_ctx                          wr_ctx;
    t_ctx                          rd_ctx;
    t_rsp                          alloc_res;
    t_rsp                          cpl_res;
    logic                          neg;

    always_comb begin
        for (int i = 0; i < SLOT_N; i++) begin
            busy_grp[i / GRP_SZ][i % GRP_SZ] = r_busy[i] | (i >= SLOTS);
        end
        for (int g = 0; g < NGRP_P; g++) begin
            grp_free[g] = ~&busy_grp[g];
        end
    end

    assign free_bit  = lowest_bit(~busy_grp[r_grp]);
    assign alloc_idx = {r_grp, free_bit};
    assign alloc_we  = i_cmd.alloc_commit && r_grp_found;
    assign cpl_idx   = r_req.tag[SLOT_W-1:0];
    assign cpl_hit   = (r_req.tag < TAG_W'(SLOTS)) && r_busy[cpl_idx];

    assign wr_ctx.flag   = r_req.event_flag;
    assign wr_ctx.param  = r_req.ast_param;
    assign wr_ctx.ast    = r_req.has_ast;
    assign wr_ctx.status = r_req.has_status;
    assign wr_ctx.rd     = r_req.is_read;

    ioctt_ram #(
        .WIDTH ($bits(t_ctx)),
        .DEPTH (SLOT_N)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (alloc_we),
        .i_waddr (alloc_idx),
        .i_wdata (wr_ctx),
        .i_raddr (cpl_idx),
        .o_rdata (rd_ctx)
    );

    always_comb begin
        alloc_res = '0;
        if (r_grp_found) begin
            alloc_res.granted_tag = 8'(alloc_idx);
        end else begin
            alloc_res.table_full = 1'b1;
        end
    end

    always_comb begin
        neg     = r_req.result[31];
        cpl_res = '0;
        if (cpl_hit) begin
            cpl_res.tag_valid = 1'b1;
            if (rd_ctx.status) begin
                cpl_res.write_status = 1'b1;
                if (neg) begin
                    cpl_res.status_code = ST_ABORT;
                end else if ((r_req.result == 32'sd0) && rd_ctx.rd) begin
                    cpl_res.status_code = ST_EOF;
                end else begin
                    cpl_res.status_code = ST_NORMAL;
                    cpl_res.byte_count  = (|r_req.result[30:16]) ? BCNT_MAX
                                                                 : r_req.result[15:0];
                end
                cpl_res.device_word = neg ? 31'd0 : r_req.result[30:0];
            end
            if (rd_ctx.flag != 7'd0) begin
                cpl_res.set_flag    = 1'b1;
                cpl_res.flag_number = rd_ctx.flag;
            end
            if (rd_ctx.ast) begin
                cpl_res.call_ast      = 1'b1;
                cpl_res.ast_param_out = rd_ctx.param;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in;
        end
        if (i_cmd.grp_load) begin
            r_grp       <= lowest_grp(grp_free);
            r_grp_found <= |grp_free;
        end
        if (i_cmd.alloc_commit) begin
            r_res <= alloc_res;
        end
        if (i_cmd.cpl_eval) begin
            r_res <= cpl_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (alloc_we) begin
                r_busy[alloc_idx] <= 1'b1;
            end
            if (i_cmd.cpl_eval && cpl_hit) begin
                r_busy[cpl_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind        = i_in.kind;
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    `IOCTT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !(r_out_valid && !i_out_ready), "pending result overwritten")
    `IOCTT_ASSERT_NXT(a_alloc_marks_busy, i_clk, i_rst_n, alloc_we, r_busy[$past(alloc_idx)], "allocated slot not marked busy")
    `IOCTT_ASSERT_NXT(a_cpl_frees_slot, i_clk, i_rst_n, i_cmd.cpl_eval && cpl_hit, !r_busy[cpl_idx], "completed slot not freed")
    `IOCTT_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_out_valid && o_out.table_full, !o_out.tag_valid && (o_out.granted_tag == 8'd0), "table full result carries other fields")

endmodule

`default_nettype wire

@@ rtl/io_completion_tag_table.sv @@
// Top level of the I/O completion tag table.
//
// Input channel (i_in_valid / o_in_ready / i_in) takes one transaction at a time:
// kind 0 allocates the lowest free slot and stores the request context, kind 1
// completes the slot named by tag, returns status and actions and frees it.
// Output channel (o_out_valid / i_out_ready / o_out) returns exactly one result
// per input transaction, in order.
// An allocate passes through group search, lowest free bit and commit, and
// output load; a completion passes through the context RAM registered read,
// evaluate and output load. The controller handles one transaction at a
// time, so a new one is accepted only after the last result is loaded.
// The output register holds a finished result while the next transaction is
// accepted and processed; a stalled receiver only stops the block when the
// next result is ready to load.
// Reset clears all busy bits and the output valid; the context RAM is not
// cleared and its read data is used only for busy slots.
`default_nettype none

module io_completion_tag_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ioctt_pkg::t_req i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ioctt_pkg::t_rsp      o_out
);

    import ioctt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ioctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ioctt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
